// File: sv/mcst_pkg.sv
// shared types and constants of the midi clock sync tracker
`timescale 1ns / 1ps

package mcst_pkg;

    // request codes
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_START    = 3'd1;
    localparam logic [2:0] REQ_CONTINUE = 3'd2;
    localparam logic [2:0] REQ_STOP     = 3'd3;
    localparam logic [2:0] REQ_SONG_POS = 3'd4;
    localparam logic [2:0] REQ_CHAN_EVT = 3'd5;

    localparam int RING_DEPTH_DEF = 64;

    // stamp window
    localparam int          WIN_LEN  = 24;
    localparam int          WIN_AW   = 5;
    localparam logic [4:0]  WIN_LAST = 5'(WIN_LEN - 1);
    localparam logic [4:0]  WIN_FULL = 5'(WIN_LEN);

    // tempo arithmetic, beat constant scaled to q8
    localparam int           QUO_W      = 34;
    localparam logic [33:0]  DIVIDEND   = 34'd14720000000;
    localparam int           DIV_STEPS  = QUO_W;
    localparam int           DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam logic [16:0]  TEMPO_MIN   = 17'd5120;
    localparam logic [16:0]  TEMPO_MAX   = 17'd76800;
    localparam logic [16:0]  TEMPO_RESET = 17'd30720;
    localparam logic [3:0]   IIR_WEIGHT  = 4'd7;
    localparam int           IIR_SHIFT   = 3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] timestamp_us;
        logic [15:0] song_position;
        logic [7:0]  event_status;
        logic [7:0]  event_data_one;
        logic [7:0]  event_data_two;
    } item_t;

    typedef struct packed {
        logic [16:0] tempo_q8;
        logic        clock_running;
        logic        playing;
        logic [31:0] tick_total;
        logic [15:0] song_pos_out;
        logic        slot_write;
        logic [5:0]  slot_index;
        logic [7:0]  slot_status;
        logic [7:0]  slot_data_one;
        logic [7:0]  slot_data_two;
        logic [7:0]  slot_tick_low;
        logic [5:0]  ring_head;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SPAN,
        ST_DIV,
        ST_IIR,
        ST_EMIT
    } state_t;

endpackage

// File: sv/mcst_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mcst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mcst_div.sv
// radix-2 restoring divider of the fixed beat constant by a 32-bit span
`timescale 1ns / 1ps

module mcst_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                divisor,
    output logic                       done,
    output logic [mcst_pkg::QUO_W-1:0] quotient
);

    import mcst_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [31:0]          dvs_reg, dvs_next;
    logic [32:0]          trial;
    logic                 ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        // dividend bits leave at the top of quo_reg, quotient bits enter at the bottom
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            rem_next  = '0;
            quo_next  = DIVIDEND;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/midi_clock_sync_tracker_top.sv
// midi clock sync tracker: transport flags, tick count, event ring slots and tempo estimate
`timescale 1ns / 1ps
// path: an accepted item passes ST_EXEC and ST_EMIT before its result is registered; a tick
// with a full window also passes ST_SPAN and, for a nonzero span, ST_DIV and ST_IIR, where it
// waits for the 34-step divider
// one item at a time: item_stall holds off new items until the state machine is back in idle
// a result waiting in the output register does not block acceptance of the next item
// reset (async, active low) clears flags, counters, head and window fill; tempo goes to 120 bpm

module midi_clock_sync_tracker_top #(
    parameter int RING_DEPTH = mcst_pkg::RING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mcst_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mcst_pkg::result_t result
);

    import mcst_pkg::*;

    localparam int HEAD_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RING_DEPTH - 1);

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [16:0]       tempo_reg, tempo_next;
    logic              run_reg, run_next;
    logic              play_reg, play_next;
    logic [31:0]       tick_reg, tick_next;
    logic [15:0]       song_reg, song_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [WIN_AW-1:0] pos_reg, pos_next;
    logic [WIN_AW-1:0] fill_reg, fill_next;
    logic              first_reg, first_next;
    logic [16:0]       est_reg, est_next;
    logic              slot_wr_reg, slot_wr_next;
    logic [HEAD_W-1:0] slot_idx_reg, slot_idx_next;
    logic [7:0]        slot_tick_reg, slot_tick_next;
    result_t           result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic              ram_we;
    logic              ram_re;
    logic [WIN_AW-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic [31:0]       span;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [20:0]       iir_sum;
    logic [HEAD_W-1:0] idx;
    logic [WIN_AW-1:0] fill_inc;

    mcst_ram #(
        .WIDTH (32),
        .DEPTH (WIN_LEN)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (item_reg.timestamp_us),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mcst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (span),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tempo_reg        <= TEMPO_RESET;
            run_reg          <= 1'b0;
            play_reg         <= 1'b0;
            tick_reg         <= '0;
            song_reg         <= '0;
            head_reg         <= '0;
            pos_reg          <= '0;
            fill_reg         <= '0;
            first_reg        <= 1'b0;
            slot_wr_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tempo_reg        <= tempo_next;
            run_reg          <= run_next;
            play_reg         <= play_next;
            tick_reg         <= tick_next;
            song_reg         <= song_next;
            head_reg         <= head_next;
            pos_reg          <= pos_next;
            fill_reg         <= fill_next;
            first_reg        <= first_next;
            slot_wr_reg      <= slot_wr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        est_reg       <= est_next;
        slot_idx_reg  <= slot_idx_next;
        slot_tick_reg <= slot_tick_next;
        result_reg    <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        tempo_next        = tempo_reg;
        run_next          = run_reg;
        play_next         = play_reg;
        tick_next         = tick_reg;
        song_next         = song_reg;
        head_next         = head_reg;
        pos_next          = pos_reg;
        fill_next         = fill_reg;
        first_next        = first_reg;
        est_next          = est_reg;
        slot_wr_next      = slot_wr_reg;
        slot_idx_next     = slot_idx_reg;
        slot_tick_next    = slot_tick_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = (pos_reg == WIN_LAST) ? '0 : pos_reg + 1'b1;
        span              = item_reg.timestamp_us - ram_rdata;
        div_start         = 1'b0;
        iir_sum           = 21'(tempo_reg) * 21'(IIR_WEIGHT) + 21'(est_reg);
        idx               = (32'(head_reg) >= 32'(RING_DEPTH)) ? '0 : head_reg;
        fill_inc          = fill_reg + 1'b1;
        item_stall        = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                slot_wr_next = 1'b0;
                state_next   = ST_EMIT;
                case (item_reg.req_type)
                    REQ_TICK:
                    begin
                        run_next  = 1'b1;
                        tick_next = tick_reg + 1'b1;
                        ram_we    = 1'b1;
                        // oldest stamp sits at the slot after the one being written
                        ram_re    = 1'b1;
                        pos_next  = ram_raddr;
                        first_next = (fill_reg < WIN_FULL);
                        if (fill_reg < WIN_FULL)
                        begin
                            fill_next = fill_inc;
                        end
                        if ((fill_reg < WIN_FULL) ? (fill_inc == WIN_FULL) : 1'b1)
                        begin
                            state_next = ST_SPAN;
                        end
                    end
                    REQ_START, REQ_CONTINUE:
                    begin
                        run_next  = 1'b1;
                        play_next = 1'b1;
                    end
                    REQ_STOP:
                    begin
                        play_next = 1'b0;
                    end
                    REQ_SONG_POS:
                    begin
                        song_next = item_reg.song_position;
                    end
                    REQ_CHAN_EVT:
                    begin
                        slot_wr_next   = 1'b1;
                        slot_idx_next  = idx;
                        slot_tick_next = tick_reg[7:0];
                        head_next      = (idx == HEAD_LAST) ? '0 : idx + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SPAN:
            begin
                if (span == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_quo < QUO_W'(TEMPO_MIN))
                    begin
                        est_next = TEMPO_MIN;
                    end
                    else if (div_quo > QUO_W'(TEMPO_MAX))
                    begin
                        est_next = TEMPO_MAX;
                    end
                    else
                    begin
                        est_next = div_quo[16:0];
                    end
                    state_next = ST_IIR;
                end
            end
            ST_IIR:
            begin
                // first estimate after the window fills is taken as is
                tempo_next = first_reg ? est_reg : 17'(iir_sum >> IIR_SHIFT);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.tempo_q8      = tempo_reg;
                    result_next.clock_running = run_reg;
                    result_next.playing       = play_reg;
                    result_next.tick_total    = tick_reg;
                    result_next.song_pos_out  = song_reg;
                    result_next.slot_write    = slot_wr_reg;
                    result_next.slot_index    = slot_wr_reg ? 6'(slot_idx_reg) : '0;
                    result_next.slot_status   = slot_wr_reg ? item_reg.event_status : '0;
                    result_next.slot_data_one = slot_wr_reg ? item_reg.event_data_one : '0;
                    result_next.slot_data_two = slot_wr_reg ? item_reg.event_data_two : '0;
                    result_next.slot_tick_low = slot_wr_reg ? slot_tick_reg : '0;
                    result_next.ring_head     = 6'(head_reg);
                    result_valid_next         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
